// ----- rtl/tga_pkg.sv -----
// shared codes and types for the tga run-length pixel decoder
package tga_pkg;

  // decoder phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_PACKET  = 3'd2;
  localparam logic [2:0] PH_PIXEL   = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_PIXEL = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_FMT   = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  // image type codes
  localparam logic [7:0] TY_MAPPED     = 8'd1;
  localparam logic [7:0] TY_TRUE       = 8'd2;
  localparam logic [7:0] TY_MAPPED_RLE = 8'd9;
  localparam logic [7:0] TY_TRUE_RLE   = 8'd10;

  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;
  localparam logic [7:0] RLE_REPEAT_BASE = 8'd127;
  localparam logic [4:0] HDR_LAST = 5'd17;

  typedef struct packed {
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/tga_pal.sv -----
// palette memory, one write and one registered read port
module tga_pal #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tga_div.sv -----
// bit-serial divider for wrapping a run past the row end
module tga_div #(
  parameter int DW = 12,
  parameter int SW = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SW-1:0]     dividend_i,
  input  logic [DW-1:0]     divisor_i,
  output tga_pkg::div_ctl_t ctl_o,
  output logic [SW-1:0]     rem_o,
  output logic [7:0]        quo_o
);

  logic          busy_q, done_q;
  logic [2:0]    step_q;
  logic [SW-1:0] rem_q;
  logic [7:0]    quo_q;
  logic [DW-1:0] dvs_q;
  logic [SW+7:0] shifted;

  // quotient never exceeds 128, so eight trial subtractions do
  assign shifted = (SW + 8)'(dvs_q) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
      end else if (busy_q) begin
        step_q <= step_q - 3'd1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if ({8'b0, rem_q} >= shifted) begin
        rem_q         <= rem_q - shifted[SW-1:0];
        quo_q[step_q] <= 1'b1;
      end
    end
  end

  assign ctl_o.busy = busy_q;
  assign ctl_o.done = done_q;
  assign rem_o      = rem_q;
  assign quo_o      = quo_q;

endmodule

// ----- rtl/tga_rle_pixel_decoder.sv -----
// tga image decoder top level: header, palette load, rle and raw pixel runs
// output: a result is registered and presented in the cycle after the transfer of the byte completing it
// throughput: one byte per cycle while the output is not back-pressured; a repeat run that wraps past
//   a row end stalls input while the serial divider splits it into rows and a column
// reset: rst_ni clears all control state asynchronously; the palette memory is not cleared
module tga_rle_pixel_decoder #(
  parameter int MAX_DIM       = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // color[31:0] column[43:32] row[55:44] run_count[63:56] rows_descend[64]
  // image_width[76:65] image_height[88:77], zero padded to 96 bits
  output logic [95:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last
);

  localparam int DW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int SW = ((DW > 8) ? DW : 8) + 1;
  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = (2 * DW > 24) ? 2 * DW : 24;

  // ---------------- state ----------------
  logic [2:0]    phase_q, phase_d;
  logic [4:0]    pos_q, pos_d;
  logic [7:0]    hdr_q [1:16];
  logic [7:0]    hdr_d [1:16];
  logic [8:0]    fill_q, fill_d;
  logic [23:0]   asm_q, asm_d;
  logic [1:0]    cnt_q, cnt_d;
  logic [7:0]    prem_q, prem_d;
  logic          prep_q, prep_d;
  logic [23:0]   done_q, done_d;
  logic [DW-1:0] col_q, col_d;
  logic [DW-1:0] row_q, row_d;
  logic [CW-1:0] area_q;

  // output register
  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [31:0]   out_color_q;
  logic          out_pal_q;
  logic [11:0]   out_col_q, out_row_q, out_iw_q, out_ih_q;
  logic [7:0]    out_run_q;
  logic          out_desc_q, out_last_q;

  // ---------------- handshake ----------------
  logic acc, b_fin, load;
  logic [7:0] b;
  tga_pkg::div_ctl_t div_ctl;
  logic [SW-1:0] div_rem;
  logic [7:0]    div_quo;

  assign s_axis_tready = !div_ctl.busy && !div_ctl.done && (!out_valid_q || m_axis_tready);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign b     = s_axis_tdata;
  assign b_fin = s_axis_tlast;

  // ---------------- header capture ----------------
  always_comb begin
    for (int i = 1; i <= 16; i++) begin
      hdr_d[i] = hdr_q[i];
      if (acc && phase_q == tga_pkg::PH_HEADER && pos_q == 5'(i)) begin
        hdr_d[i] = b;
      end
    end
  end

  logic [15:0] w16, h16;
  logic [7:0]  ty;
  logic        mapped, rle, flip;
  logic [8:0]  pal_len, pal_lim;
  assign w16     = {hdr_d[13], hdr_d[12]};
  assign h16     = {hdr_d[15], hdr_d[14]};
  assign ty      = hdr_d[2];
  assign mapped  = (ty == tga_pkg::TY_MAPPED) || (ty == tga_pkg::TY_MAPPED_RLE);
  assign rle     = (ty == tga_pkg::TY_MAPPED_RLE) || (ty == tga_pkg::TY_TRUE_RLE);
  assign flip    = ({hdr_d[11], hdr_d[10]} == 16'd0);
  assign pal_len = (hdr_d[1] != 8'd0) ? {1'b0, hdr_d[5]} : 9'd0;
  assign pal_lim = (pal_len > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : pal_len;

  // header check, evaluated on the final header byte
  logic [2:0] chk;
  always_comb begin
    chk = tga_pkg::ST_PIXEL;
    if (w16 == 16'd0 || h16 == 16'd0) begin
      chk = tga_pkg::ST_EMPTY;
    end else if (!(ty == tga_pkg::TY_MAPPED || ty == tga_pkg::TY_TRUE ||
                   ty == tga_pkg::TY_MAPPED_RLE || ty == tga_pkg::TY_TRUE_RLE)) begin
      chk = tga_pkg::ST_TYPE;
    end else if ({1'b0, w16} > 17'(MAX_DIM - 1) || {1'b0, h16} > 17'(MAX_DIM - 1)) begin
      chk = tga_pkg::ST_FMT;
    end else if (mapped) begin
      if (hdr_d[6] != 8'd0 || hdr_d[4] != 8'd0 || hdr_d[3] != 8'd0 ||
          (hdr_d[7] != tga_pkg::BPP_24 && hdr_d[7] != tga_pkg::BPP_32)) begin
        chk = tga_pkg::ST_FMT;
      end
    end else begin
      if (hdr_d[5] != 8'd0 || hdr_d[6] != 8'd0 || hdr_d[1] != 8'd0 ||
          (hdr_d[16] != tga_pkg::BPP_24 && hdr_d[16] != tga_pkg::BPP_32)) begin
        chk = tga_pkg::ST_FMT;
      end
    end
  end

  // ---------------- byte gathering ----------------
  logic [31:0] gval;
  logic [4:0]  unit_n;
  logic        gdone;
  assign gval   = {8'b0, asm_q} | (32'(b) << {cnt_q, 3'b000});
  assign unit_n = (phase_q == tga_pkg::PH_PALETTE) ? hdr_d[7][7:3] :
                  (mapped ? 5'd1 : hdr_d[16][7:3]);
  assign gdone  = ({3'b0, cnt_q} + 5'd1) >= unit_n;

  logic [31:0] argb;
  assign argb = (unit_n == 5'd3) ? {8'hFF, gval[23:0]} : gval;

  // ---------------- per-byte step ----------------
  logic          prod;
  logic [2:0]    o_status;
  logic [31:0]   o_color;
  logic          o_pal, o_desc, o_last;
  logic [11:0]   o_col, o_row;
  logic [7:0]    o_run;
  logic          pal_we, pal_re;
  logic          div_start;
  logic [SW-1:0] sum;
  logic [CW-1:0] remaining;
  logic [7:0]    run;

  assign remaining = area_q - CW'(done_q);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    asm_d     = asm_q;
    cnt_d     = cnt_q;
    prem_d    = prem_q;
    prep_d    = prep_q;
    done_d    = done_q;
    col_d     = col_q;
    row_d     = row_q;
    prod      = 1'b0;
    o_status  = tga_pkg::ST_PIXEL;
    o_color   = '0;
    o_pal     = 1'b0;
    o_col     = '0;
    o_row     = '0;
    o_run     = '0;
    o_desc    = 1'b0;
    o_last    = 1'b0;
    pal_we    = 1'b0;
    pal_re    = 1'b0;
    div_start = 1'b0;
    run       = 8'd1;
    sum       = '0;

    // a finished division lands in the counters while input is held
    if (div_ctl.done) begin
      col_d = DW'(div_rem);
      row_d = row_q + DW'(div_quo);
    end

    if (acc) begin
      unique case (phase_q)
        tga_pkg::PH_HEADER: begin
          pos_d = pos_q + 5'd1;
          if (pos_q == tga_pkg::HDR_LAST) begin
            if (chk != tga_pkg::ST_PIXEL) begin
              prod     = 1'b1;
              o_status = chk;
              o_last   = 1'b1;
              phase_d  = tga_pkg::PH_SKIP;
            end else if (mapped && pal_len != 9'd0) begin
              phase_d = tga_pkg::PH_PALETTE;
            end else begin
              phase_d = rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
            end
          end
        end
        tga_pkg::PH_PALETTE: begin
          if (gdone) begin
            asm_d  = '0;
            cnt_d  = '0;
            pal_we = (fill_q < 9'(PALETTE_DEPTH));
            fill_d = fill_q + 9'd1;
            if (fill_d >= pal_len) begin
              phase_d = rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
            end
          end else begin
            asm_d = gval[23:0];
            cnt_d = cnt_q + 2'd1;
          end
        end
        tga_pkg::PH_PACKET: begin
          if (b > tga_pkg::RLE_REPEAT_BASE) begin
            prep_d = 1'b1;
            prem_d = b - tga_pkg::RLE_REPEAT_BASE;
          end else begin
            prep_d = 1'b0;
            prem_d = b + 8'd1;
          end
          phase_d = tga_pkg::PH_PIXEL;
        end
        tga_pkg::PH_PIXEL: begin
          if (gdone) begin
            asm_d = '0;
            cnt_d = '0;
            if (mapped) begin
              if ({1'b0, gval[7:0]} < pal_lim) begin
                pal_re = 1'b1;
                o_pal  = 1'b1;
              end
            end else begin
              o_color = argb;
            end
            if (rle) begin
              if (prep_q) begin
                run    = prem_q;
                prem_d = '0;
              end else begin
                prem_d = prem_q - 8'd1;
              end
              if (CW'(run) > remaining) begin
                run = 8'(remaining);
              end
              if (prem_d == 8'd0) begin
                phase_d = tga_pkg::PH_PACKET;
              end
            end
            prod     = 1'b1;
            o_col    = 12'(col_q);
            o_row    = flip ? 12'(h16 - 16'd1 - 16'(row_q)) : 12'(row_q);
            o_run    = run;
            o_desc   = flip;
            // advance the raster position, wrapping at the row end
            sum = SW'(col_q) + SW'(run);
            if (sum < SW'(w16)) begin
              col_d = DW'(sum);
            end else if (run == 8'd1) begin
              col_d = '0;
              row_d = row_q + DW'(1);
            end else begin
              div_start = 1'b1;
            end
            done_d = done_q + 24'(run);
            if (CW'(done_d) >= area_q) begin
              phase_d = tga_pkg::PH_DONE;
            end
          end else begin
            asm_d = gval[23:0];
            cnt_d = cnt_q + 2'd1;
          end
        end
        default: begin
        end
      endcase

      if (b_fin) begin
        if (phase_d == tga_pkg::PH_SKIP) begin
          // error already reported
        end else if (phase_d == tga_pkg::PH_DONE) begin
          if (prod) begin
            o_last = 1'b1;
          end else begin
            prod     = 1'b1;
            o_status = tga_pkg::ST_DONE;
            o_last   = 1'b1;
          end
        end else begin
          prod     = 1'b1;
          o_status = tga_pkg::ST_TRUNC;
          o_color  = '0;
          o_pal    = 1'b0;
          o_col    = '0;
          o_row    = '0;
          o_run    = '0;
          o_desc   = 1'b0;
          o_last   = 1'b1;
        end
        // back to the header for the next file
        phase_d   = tga_pkg::PH_HEADER;
        pos_d     = '0;
        fill_d    = '0;
        asm_d     = '0;
        cnt_d     = '0;
        prem_d    = '0;
        prep_d    = 1'b0;
        done_d    = '0;
        col_d     = '0;
        row_d     = '0;
        div_start = 1'b0;
      end
    end
  end

  assign load = acc && prod;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tga_pkg::PH_HEADER;
      pos_q       <= '0;
      fill_q      <= '0;
      asm_q       <= '0;
      cnt_q       <= '0;
      prem_q      <= '0;
      prep_q      <= 1'b0;
      done_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 1; i <= 16; i++) begin
        hdr_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      asm_q   <= asm_d;
      cnt_q   <= cnt_d;
      prem_q  <= prem_d;
      prep_q  <= prep_d;
      done_q  <= done_d;
      col_q   <= col_d;
      row_q   <= row_d;
      for (int i = 1; i <= 16; i++) begin
        hdr_q[i] <= (acc && b_fin) ? 8'd0 : hdr_d[i];
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pixel count of the image, ready well before the first pixel
  always_ff @(posedge clk_i) begin
    area_q <= CW'({hdr_q[13], hdr_q[12]} * {hdr_q[15], hdr_q[14]});
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= o_status;
      out_color_q  <= o_color;
      out_pal_q    <= o_pal;
      out_col_q    <= o_col;
      out_row_q    <= o_row;
      out_run_q    <= o_run;
      out_desc_q   <= o_desc;
      out_iw_q     <= 12'(w16);
      out_ih_q     <= 12'(h16);
      out_last_q   <= o_last;
    end
  end

  // ---------------- submodules ----------------
  logic [31:0] pal_rdata;

  tga_pal #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (acc && pal_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (argb),
    .re_i    (load && pal_re),
    .raddr_i (gval[AW-1:0]),
    .rdata_o (pal_rdata)
  );

  tga_div #(
    .DW (DW),
    .SW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (DW'(w16)),
    .ctl_o      (div_ctl),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  // ---------------- outputs ----------------
  logic [31:0] color_out;
  assign color_out     = out_pal_q ? pal_rdata : out_color_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_ih_q, out_iw_q, out_desc_q, out_run_q,
                          out_row_q, out_col_q, color_out};

  // ---------------- checks ----------------
  a_div_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.busy |-> !s_axis_tready)
    else $error("input taken while a row wrap is being divided");

  a_file_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && b_fin) |=> (phase_q == tga_pkg::PH_HEADER && pos_q == 5'd0))
    else $error("decoder did not restart after the final byte");

  a_done_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tga_pkg::PH_DONE) |-> (CW'(done_q) >= area_q))
    else $error("image marked complete before all pixels");

endmodule
